// ===== design/assert_macros.svh =====
// Assertion helpers shared by the parser modules.
// Both sample on clk and are quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/dpp_pkg.sv =====
package dpp_pkg;

  // Full-scale value of a number
  localparam int SCALE = 100000;

  localparam int NUM_W  = 17;
  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int DIG_W  = 4;

  // Accumulator holds values below twice the scale; an integer step needs ten times more
  localparam int ACC_W = $clog2(2 * SCALE);
  localparam int INT_W = $clog2(10 * SCALE + 10);

  // Fraction digit weights: scale/1000, then divided by ten per digit
  localparam int WEIGHT0 = SCALE / 1000;
  localparam int WGT_W   = $clog2(WEIGHT0 + 1);
  localparam int PCT_STEP = SCALE / 100;
  localparam int PCT_MAX  = 100;

  localparam int WIDX_W = 3;
  localparam logic [WIDX_W-1:0] WIDX_LAST = 3'd4;

  localparam logic [WGT_W-1:0] WGT_0 = WGT_W'(WEIGHT0);
  localparam logic [WGT_W-1:0] WGT_1 = WGT_W'(WEIGHT0 / 10);
  localparam logic [WGT_W-1:0] WGT_2 = WGT_W'(WEIGHT0 / 100);
  localparam logic [WGT_W-1:0] WGT_3 = WGT_W'(WEIGHT0 / 1000);

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_PCT  = 8'h25;
  localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

  // Character classes
  localparam logic [1:0] CLS_DIGIT = 2'd0;
  localparam logic [1:0] CLS_PCT   = 2'd1;
  localparam logic [1:0] CLS_DOT   = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ABS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR = 2'd2;

  // Parse phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_INT  = 2'd1;
  localparam logic [1:0] PH_FRAC = 2'd2;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = 2;

  typedef struct packed {
    logic [1:0]       cls;
    logic [DIG_W-1:0] digit;
  } dpp_item_t;

  typedef struct packed {
    logic      valid;
    dpp_item_t item;
  } dpp_head_t;

  function automatic logic [WGT_W-1:0] frac_weight(input logic [WIDX_W-1:0] idx);
    logic [WGT_W-1:0] w;
    case (idx)
      3'd0: w = WGT_0;
      3'd1: w = WGT_1;
      3'd2: w = WGT_2;
      3'd3: w = WGT_3;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== design/dpp_front.sv =====
`include "assert_macros.svh"

module dpp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [dpp_pkg::CHAR_W-1:0] char_code,
  output dpp_pkg::dpp_head_t         head,
  input  logic                       pop
);
  import dpp_pkg::*;

  dpp_item_t             slots [Q_DEPTH];
  logic [Q_AW-1:0]       wptr;
  logic [Q_AW-1:0]       rptr;
  logic [Q_CW-1:0]       count;
  dpp_item_t             item_in;
  logic                  push;
  logic                  is_digit;
  logic [CHAR_W-1:0]     digit_code;

  // Classify the incoming character
  always_comb begin
    is_digit   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    digit_code = char_code - CHAR_ZERO;
    item_in.digit = is_digit ? digit_code[DIG_W-1:0] : '0;
    if (is_digit) begin
      item_in.cls = CLS_DIGIT;
    end else if (char_code == CHAR_PCT) begin
      item_in.cls = CLS_PCT;
    end else if (char_code == CHAR_DOT) begin
      item_in.cls = CLS_DOT;
    end else begin
      item_in.cls = CLS_OTHER;
    end
  end

  assign in_stall = (count == Q_CW'(Q_DEPTH));
  assign push     = in_valid && !in_stall;

  assign head.valid = (count != '0);
  assign head.item  = slots[rptr];

  // Store classified characters
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= item_in;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + Q_CW'(push) - Q_CW'(pop);
    end
  end

  `ASSERT_IMPL(a_pop_nonempty, pop, count != '0)
  `ASSERT_IMPL(a_count_bound, 1'b1, count <= Q_CW'(Q_DEPTH))

endmodule

// ===== design/dpp_back.sv =====
`include "assert_macros.svh"

module dpp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  dpp_pkg::dpp_head_t         head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dpp_pkg::KIND_W-1:0] kind,
  output logic [dpp_pkg::NUM_W-1:0]  number,
  output logic                       end_consumed
);
  import dpp_pkg::*;

  localparam logic [ACC_W-1:0] SCALE_ACC = ACC_W'(SCALE);
  localparam logic [INT_W-1:0] SCALE_INT = INT_W'(SCALE);

  logic [1:0]          phase;
  logic [1:0]          phase_next;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    acc_next;
  logic [WIDX_W-1:0]   widx;
  logic [WIDX_W-1:0]   widx_next;

  logic                produce;
  logic [KIND_W-1:0]   res_kind;
  logic [ACC_W-1:0]    res_value;
  logic                res_used;

  logic [DIG_W-1:0]    d;
  logic [WGT_W-1:0]    weight;
  logic [WGT_W+3:0]    frac_prod;
  logic [ACC_W-1:0]    frac_sum;
  logic [INT_W-1:0]    int_val;
  logic [ACC_W-1:0]    rel_src;
  logic                rel_over;
  logic [ACC_W-1:0]    rel_val;

  // Datapath terms for each kind of step
  always_comb begin
    d         = head.item.digit;
    weight    = frac_weight(widx);
    frac_prod = (WGT_W+4)'(d) * (WGT_W+4)'(weight);
    frac_sum  = acc + ACC_W'(frac_prod);
    int_val   = INT_W'(acc) * INT_W'(10) + INT_W'(d);
    rel_src   = (phase == PH_INT) ? acc : '0;
    rel_over  = rel_src > ACC_W'(PCT_MAX);
    rel_val   = ACC_W'(rel_src[6:0]) * ACC_W'(PCT_STEP);
  end

  // Parse step for the character at the head of the queue
  always_comb begin
    produce    = 1'b0;
    res_kind   = KIND_ERR;
    res_value  = '0;
    res_used   = 1'b0;
    phase_next = phase;
    acc_next   = acc;
    widx_next  = widx;
    case (phase)
      PH_FRAC: begin
        if (head.item.cls == CLS_DIGIT) begin
          acc_next  = frac_sum;
          widx_next = (widx == WIDX_LAST) ? widx : widx + 1'b1;
        end else if (head.item.cls == CLS_PCT) begin
          produce  = 1'b1;
          res_used = 1'b1;
          if (acc <= SCALE_ACC) begin
            res_kind  = KIND_REL;
            res_value = acc;
          end
        end else begin
          produce = 1'b1;
        end
      end
      PH_INT: begin
        if (head.item.cls == CLS_DIGIT) begin
          if (int_val >= SCALE_INT) begin
            produce  = 1'b1;
            res_used = 1'b1;
          end else begin
            acc_next = ACC_W'(int_val);
          end
        end else if (head.item.cls == CLS_OTHER) begin
          produce   = 1'b1;
          res_kind  = KIND_ABS;
          res_value = acc;
        end else if (rel_over) begin
          produce  = 1'b1;
          res_used = 1'b1;
        end else if (head.item.cls == CLS_PCT) begin
          produce   = 1'b1;
          res_used  = 1'b1;
          res_kind  = KIND_REL;
          res_value = rel_val;
        end else begin
          acc_next   = rel_val;
          widx_next  = '0;
          phase_next = PH_FRAC;
        end
      end
      default: begin
        if (head.item.cls == CLS_DIGIT) begin
          acc_next   = ACC_W'(d);
          widx_next  = '0;
          phase_next = PH_INT;
        end else if (head.item.cls == CLS_DOT) begin
          acc_next   = rel_val;
          widx_next  = '0;
          phase_next = PH_FRAC;
        end else begin
          produce = 1'b1;
        end
      end
    endcase
    // Clear state after every result
    if (produce) begin
      phase_next = PH_IDLE;
      acc_next   = '0;
      widx_next  = '0;
    end
  end

  // Take the head unless its result has nowhere to go
  assign pop = head.valid && (!produce || !out_valid || !out_stall);

  // Advance parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      acc   <= '0;
      widx  <= '0;
    end else if (pop) begin
      phase <= phase_next;
      acc   <= acc_next;
      widx  <= widx_next;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && produce) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && produce) begin
      kind         <= res_kind;
      number       <= (res_kind == KIND_ERR) ? '0 : NUM_W'(res_value);
      end_consumed <= res_used;
    end
  end

  `ASSERT_IMPL(a_int_range, phase == PH_INT, acc < SCALE_ACC)
  `ASSERT_IMPL(a_err_zero, out_valid && kind == KIND_ERR, number == '0)
  `ASSERT_NEXT(a_no_overwrite, out_valid && out_stall && !(pop && produce), out_valid)

endmodule

// ===== design/decimal_percent_number_parser.sv =====
// Decimal / percentage number parser.
// Input channel: in_valid, in_stall, char_code. One character per transfer;
// a run of characters forms one number, ended by a character that does not
// belong to it (a zero byte works).
// Output channel: out_valid, out_stall, kind, number, end_consumed. One
// transfer per parsed number: kind absolute, relative or error, number in
// scale units (zero on error), end_consumed set when the final character
// was part of the number.
// Throughput: one character per cycle while no result waits on a stalled
// receiver. A two-entry queue sits between the character classifier and
// the parse state machine; the state machine takes one queued character
// per cycle, unless its result must wait, and feeds an output register.
// A result passes through the queue stage, then the output register.
// When the receiver stalls, the result holds in the output register; the
// state machine keeps taking characters that give no result, and the queue
// fills only once a second result is waiting, then in_stall rises.
// Reset (rst, synchronous): empties the queue, drops any pending result and
// returns the parser to idle with its value cleared.
module decimal_percent_number_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 char_code,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dpp_pkg::KIND_W-1:0] kind,
  output logic [dpp_pkg::NUM_W-1:0]  number,
  output logic                       end_consumed
);
  import dpp_pkg::*;

  dpp_head_t head;
  logic      pop;

  dpp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .head      (head),
    .pop       (pop)
  );

  dpp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .number       (number),
    .end_consumed (end_consumed)
  );

endmodule
